@@ sv/oneshot_periodic_timer_bank_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the oneshot/periodic timer bank core
// Shorthand for clocked implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ONESHOT_PERIODIC_TIMER_BANK_CORE_MACROS_SVH
`define ONESHOT_PERIODIC_TIMER_BANK_CORE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define OPTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define OPTB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/optb_pkg.sv @@
// ----------------------------------------------------------------------------
// optb_pkg
// Shared codes, widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package optb_pkg;

    localparam int NUM_TIMERS_DEF = 8;

    localparam int ACT_W    = 3;
    localparam int SLOT_W   = 3;
    localparam int MS_W     = 16;
    localparam int US_W     = 16;
    localparam int KIND_W   = 2;
    localparam int MODE_W   = 2;
    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 26;
    localparam int MULT_W   = 10;

    localparam logic [MULT_W-1:0] US_PER_MS = 10'd1000;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SETP    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DESTROY = 3'd6;

    // Slot modes
    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_OK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted beat
        logic tick;   // accepted beat is a tick: advance time
        logic rd_en;  // read period/expiry memories
        logic scan;   // address by scan indexes instead of command slot
        logic exec;   // execute the command and push its result
        logic ev_en;  // evaluate the slot at the evaluation index
        logic flush;  // push the held firing as the final result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic pend_valid;
        logic fire;
    } sts_t;

endpackage

@@ sv/optb_ctrl.sv @@
// ----------------------------------------------------------------------------
// optb_ctrl
// Sequencer: command read/execute steps and the pipelined tick scan.
// ----------------------------------------------------------------------------
module optb_ctrl #(
    parameter int  NUM_TIMERS = optb_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [optb_pkg::ACT_W-1:0]  action,
    input  optb_pkg::sts_t              sts,
    output optb_pkg::cmd_t              cmd,
    output logic [IDX_W-1:0]            rd_idx,
    output logic [IDX_W-1:0]            ev_idx
);
    import optb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CRD   = 3'd1;
    localparam logic [2:0] S_CEX   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0] ev_idx_reg, ev_idx_next;

    assign rd_idx = rd_cnt_reg[IDX_W-1:0];
    assign ev_idx = ev_idx_reg;

    always_comb
    begin
        logic stall;
        logic rd_active;
        cmd           = '0;
        in_ready      = 1'b0;
        state_next    = state_reg;
        rd_cnt_next   = rd_cnt_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        stall         = ev_valid_reg && sts.fire && sts.pend_valid && !sts.out_free;
        rd_active     = (rd_cnt_reg != CNT_W'(NUM_TIMERS));
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (action == ACT_TICK)
                    begin
                        cmd.tick      = 1'b1;
                        rd_cnt_next   = '0;
                        ev_valid_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_CRD;
                    end
                end
            end
            S_CRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CEX;
            end
            S_CEX:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!stall)
                begin
                    cmd.rd_en     = rd_active;
                    cmd.ev_en     = ev_valid_reg;
                    ev_valid_next = rd_active;
                    ev_idx_next   = rd_cnt_reg[IDX_W-1:0];
                    if (rd_active)
                    begin
                        rd_cnt_next = rd_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                cmd.scan = 1'b1;
                if (!sts.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_cnt_reg   <= '0;
            ev_valid_reg <= 1'b0;
            ev_idx_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            ev_valid_reg <= ev_valid_next;
            ev_idx_reg   <= ev_idx_next;
        end
    end

endmodule

@@ sv/optb_dpath.sv @@
// ----------------------------------------------------------------------------
// optb_dpath
// Time counter, slot state, period/expiry memories, held firing, output stage.
// ----------------------------------------------------------------------------
module optb_dpath #(
    parameter int  NUM_TIMERS = optb_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  optb_pkg::cmd_t                cmd,
    input  logic [IDX_W-1:0]              rd_idx,
    input  logic [IDX_W-1:0]              ev_idx,
    output optb_pkg::sts_t                sts,
    input  logic [optb_pkg::ACT_W-1:0]    action,
    input  logic [optb_pkg::SLOT_W-1:0]   slot,
    input  logic [optb_pkg::MS_W-1:0]     period_ms,
    input  logic                          oneshot,
    input  logic [optb_pkg::US_W-1:0]     elapsed_us,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [optb_pkg::KIND_W-1:0]   kind,
    output logic [optb_pkg::SLOT_W-1:0]   slot_out,
    output logic                          is_running,
    output logic                          last
);
    import optb_pkg::*;

    // Control state
    logic [TIME_W-1:0] time_reg;
    logic [MODE_W-1:0] mode_reg [NUM_TIMERS];
    logic              os_flag_reg [NUM_TIMERS];
    logic              per_vld_reg [NUM_TIMERS];
    logic              pend_valid_reg;
    logic              out_valid_reg;

    // Captured beat
    logic [ACT_W-1:0]  act_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [MS_W-1:0]   ms_reg;
    logic              os_reg;

    // Memories and registered read data
    logic [PERIOD_W-1:0] per_mem [NUM_TIMERS];
    logic [TIME_W-1:0]   exp_mem [NUM_TIMERS];
    logic [PERIOD_W-1:0] per_rd_reg;
    logic                per_rd_vld_reg;
    logic [TIME_W-1:0]   exp_rd_reg;

    // Held firing and output stage payload
    logic [SLOT_W-1:0] pend_slot_reg;
    logic              pend_run_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [SLOT_W-1:0] slot_out_reg;
    logic              run_reg;
    logic              last_reg;

    logic [IDX_W-1:0]    item_idx, sel_idx, rd_addr;
    logic                in_range;
    logic [MODE_W-1:0]   mode_sel;
    logic                running_sel;
    logic                os_sel;
    logic [PERIOD_W-1:0] per_eff;
    logic [PERIOD_W-1:0] ms_ext, k_ext, new_per;
    logic [TIME_W-1:0]   reload;
    logic                fire;
    logic                ev_fire;

    logic [KIND_W-1:0] res_kind;
    logic              res_run;
    logic              per_we;
    logic              exp_we_cmd;
    logic              mode_we;
    logic [MODE_W-1:0] mode_new;
    logic              os_we;

    logic              exp_we;
    logic [IDX_W-1:0]  exp_wa;
    logic              push;

    assign item_idx    = IDX_W'(slot_reg);
    assign in_range    = (int'(slot_reg) < NUM_TIMERS);
    assign sel_idx     = cmd.scan ? ev_idx : item_idx;
    assign rd_addr     = cmd.scan ? rd_idx : item_idx;
    assign mode_sel    = mode_reg[sel_idx];
    assign running_sel = (mode_sel == MODE_RUNNING);
    assign os_sel      = os_flag_reg[sel_idx];
    assign per_eff     = per_rd_vld_reg ? per_rd_reg : '0;
    assign ms_ext      = {{(PERIOD_W-MS_W){1'b0}}, ms_reg};
    assign k_ext       = {{(PERIOD_W-MULT_W){1'b0}}, US_PER_MS};
    assign new_per     = ms_ext * k_ext;
    assign reload      = time_reg + {{(TIME_W-PERIOD_W){1'b0}}, per_eff};
    assign fire        = running_sel && (time_reg >= exp_rd_reg);
    assign ev_fire     = cmd.ev_en && fire;

    assign exp_we = (cmd.exec && exp_we_cmd) || (ev_fire && !os_sel);
    assign exp_wa = cmd.exec ? item_idx : ev_idx;
    assign push   = cmd.exec || cmd.flush || (ev_fire && pend_valid_reg);

    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.fire       = fire;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign slot_out   = slot_out_reg;
    assign is_running = run_reg;
    assign last       = last_reg;

    // Command decode against the addressed slot's current mode
    always_comb
    begin
        res_kind   = KIND_OK;
        res_run    = running_sel;
        per_we     = 1'b0;
        exp_we_cmd = 1'b0;
        mode_we    = 1'b0;
        mode_new   = mode_sel;
        os_we      = 1'b0;
        if (!in_range)
        begin
            res_kind = KIND_INVALID;
            res_run  = 1'b0;
        end
        else
        begin
            unique case (act_reg)
                ACT_CREATE:
                begin
                    per_we   = 1'b1;
                    os_we    = 1'b1;
                    mode_we  = 1'b1;
                    mode_new = MODE_CREATED;
                    res_run  = 1'b0;
                end
                ACT_START:
                begin
                    if (running_sel)
                    begin
                        res_kind = KIND_INVALID;
                    end
                    else
                    begin
                        exp_we_cmd = 1'b1;
                        mode_we    = 1'b1;
                        mode_new   = MODE_RUNNING;
                        res_run    = 1'b1;
                    end
                end
                ACT_STOP:
                begin
                    if (!running_sel)
                    begin
                        res_kind = KIND_INVALID;
                    end
                    else
                    begin
                        mode_we  = 1'b1;
                        mode_new = MODE_STOPPED;
                        res_run  = 1'b0;
                    end
                end
                ACT_SETP:
                begin
                    if (mode_sel != MODE_CREATED && !running_sel)
                    begin
                        res_kind = KIND_INVALID;
                    end
                    else
                    begin
                        per_we = 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    res_kind = KIND_OK;
                end
                ACT_DESTROY:
                begin
                    if (running_sel)
                    begin
                        mode_we  = 1'b1;
                        mode_new = MODE_STOPPED;
                    end
                    res_run = 1'b0;
                end
                default:
                begin
                    res_kind = KIND_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                mode_reg[i]    <= MODE_STOPPED;
                os_flag_reg[i] <= 1'b0;
                per_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.load && cmd.tick)
            begin
                time_reg <= time_reg + {{(TIME_W-US_W){1'b0}}, elapsed_us};
            end
            if (cmd.exec && mode_we)
            begin
                mode_reg[item_idx] <= mode_new;
            end
            if (ev_fire && os_sel)
            begin
                mode_reg[ev_idx] <= MODE_STOPPED;
            end
            if (cmd.exec && os_we)
            begin
                os_flag_reg[item_idx] <= os_reg;
            end
            if (cmd.exec && per_we)
            begin
                per_vld_reg[item_idx] <= 1'b1;
            end
            if (cmd.load || cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (ev_fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: captured beat, memories, read data, held firing, output stage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            slot_reg <= slot;
            ms_reg   <= period_ms;
            os_reg   <= oneshot;
        end
        if (cmd.exec && per_we)
        begin
            per_mem[item_idx] <= new_per;
        end
        if (exp_we)
        begin
            exp_mem[exp_wa] <= reload;
        end
        if (cmd.rd_en)
        begin
            per_rd_reg     <= per_mem[rd_addr];
            per_rd_vld_reg <= per_vld_reg[rd_addr];
            exp_rd_reg     <= exp_mem[rd_addr];
        end
        if (ev_fire)
        begin
            pend_slot_reg <= SLOT_W'(ev_idx);
            pend_run_reg  <= !os_sel;
        end
        if (push)
        begin
            if (cmd.exec)
            begin
                kind_reg     <= res_kind;
                slot_out_reg <= slot_reg;
                run_reg      <= res_run;
                last_reg     <= 1'b1;
            end
            else
            begin
                kind_reg     <= KIND_FIRED;
                slot_out_reg <= pend_slot_reg;
                run_reg      <= pend_run_reg;
                last_reg     <= cmd.flush;
            end
        end
    end

endmodule

@@ sv/oneshot_periodic_timer_bank_core.sv @@
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_bank_core
// Bank of oneshot/periodic timer slots over a 48-bit microsecond counter.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Beat contents
//  --------+-----------+----------------------+-----------------------------------
//  in      | to core   | in_valid / in_ready  | action, slot, period_ms, oneshot,
//          |           |                      | elapsed_us
//  out     | from core | out_valid / out_ready| kind, slot_out, is_running, last
//
//  A command steps from accept back to ready through capture, memory read and
//  execute. In a tick, unless stalled, the scan reads one slot's
//  period and expiry from the memories per cycle and evaluates the previous
//  slot in the same cycle, then a final flush step releases the last firing.
//  Reset (rst_n low, asynchronous) clears the time, all slot modes, oneshot
//  flags and period valid bits; periods and expiries need no clearing pass.
//  A full output register holds a command at its execute step and the final
//  release; the scan holds only when a firing is due while an earlier one
//  waits in the hold register behind a full output register.
//
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_bank_core #(
    parameter int NUM_TIMERS = optb_pkg::NUM_TIMERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [optb_pkg::ACT_W-1:0]    action,
    input  logic [optb_pkg::SLOT_W-1:0]   slot,
    input  logic [optb_pkg::MS_W-1:0]     period_ms,
    input  logic                          oneshot,
    input  logic [optb_pkg::US_W-1:0]     elapsed_us,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [optb_pkg::KIND_W-1:0]   kind,
    output logic [optb_pkg::SLOT_W-1:0]   slot_out,
    output logic                          is_running,
    output logic                          last
);
    import optb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] ev_idx;

    // Sequencer: decides which step runs each cycle
    optb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .ev_idx   (ev_idx)
    );

    // Slot storage, time counter and the output register
    optb_dpath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_idx     (rd_idx),
        .ev_idx     (ev_idx),
        .sts        (sts),
        .action     (action),
        .slot       (slot),
        .period_ms  (period_ms),
        .oneshot    (oneshot),
        .elapsed_us (elapsed_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .slot_out   (slot_out),
        .is_running (is_running),
        .last       (last)
    );

endmodule

@@ sv/optb_checker.sv @@
// ----------------------------------------------------------------------------
// optb_checker
// Port-level checks for the timer bank core, bound to the top level.
// ----------------------------------------------------------------------------
`include "oneshot_periodic_timer_bank_core_macros.svh"

module optb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [optb_pkg::KIND_W-1:0]   kind,
    input logic [optb_pkg::SLOT_W-1:0]   slot_out,
    input logic                          is_running,
    input logic                          last
);
    import optb_pkg::*;

    // Hold a stalled result beat
    `OPTB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(slot_out) && $stable(is_running) && $stable(last), "result beat changed while stalled")

    // Drop ready in the cycle after every accepted beat
    `OPTB_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held high right after accept")

    // Command answers are single beats
    `OPTB_ASSERT_IMP(a_cmd_single, out_valid && kind != KIND_FIRED, last, "command result without last")

    // No new beat while a tick still has firings to deliver
    `OPTB_ASSERT_IMP(a_fire_burst_busy, out_valid && kind == KIND_FIRED && !last, !in_ready, "ready during an unfinished tick")

endmodule

bind oneshot_periodic_timer_bank_core optb_checker u_optb_checker (.*);

@@ verif/oneshot_periodic_timer_bank_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_bank_core_tb
// Self-checking bench for the timer bank core. It sends directed and random
// command and tick beats, mirrors every slot in a behavioral scoreboard, and
// compares each result beat field by field against the predicted stream.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_bank_core_tb;

    import optb_pkg::*;

    localparam int NUM_SLOTS   = NUM_TIMERS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int RANDOM_BEATS = 300;
    // Code 7 is not assigned to any action; the core must answer it as invalid.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              running;
        logic              last;
    } timer_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds a shadow copy of the bank and the queue of results
    // still owed by the core.
    // ------------------------------------------------------------------------
    class timer_result_board;
        logic [TIME_W-1:0]   now_us;
        logic [MODE_W-1:0]   mode      [NUM_SLOTS];
        logic [PERIOD_W-1:0] period_us [NUM_SLOTS];
        logic                one_shot  [NUM_SLOTS];
        logic [TIME_W-1:0]   expiry_us [NUM_SLOTS];
        timer_result_t       owed[$];
        int                  mismatches;

        function new();
            now_us = '0;
            mismatches = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                mode[i]      = MODE_STOPPED;
                period_us[i] = '0;
                one_shot[i]  = 1'b0;
                expiry_us[i] = '0;
            end
        endfunction

        // Predict the results of one accepted input beat and queue them.
        function void note_beat(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] s,
                                logic [MS_W-1:0] pms, logic os, logic [US_W-1:0] el);
            timer_result_t r;
            timer_result_t held;
            logic          have_held;
            logic [KIND_W-1:0]   k;
            logic [PERIOD_W-1:0] p;
            have_held = 1'b0;
            k = KIND_OK;
            p = PERIOD_W'(32'(pms) * 32'(US_PER_MS));
            if (act == ACT_TICK)
            begin
                // Advance time, then fire every due running slot in slot order.
                now_us = now_us + TIME_W'(el);
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (mode[i] == MODE_RUNNING && now_us >= expiry_us[i])
                    begin
                        if (one_shot[i])
                            mode[i] = MODE_STOPPED;
                        else
                            expiry_us[i] = now_us + TIME_W'(period_us[i]);
                        if (have_held)
                            owed.push_back(held);
                        held.kind    = KIND_FIRED;
                        held.slot    = SLOT_W'(i);
                        held.running = (mode[i] == MODE_RUNNING);
                        held.last    = 1'b0;
                        have_held    = 1'b1;
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    owed.push_back(held);
                end
                return;
            end
            if (int'(s) >= NUM_SLOTS)
            begin
                r.kind = KIND_INVALID;
                r.slot = s;
                r.running = 1'b0;
                r.last = 1'b1;
                owed.push_back(r);
                return;
            end
            case (act)
                ACT_CREATE:
                begin
                    period_us[s] = p;
                    one_shot[s]  = os;
                    mode[s]      = MODE_CREATED;
                end
                ACT_START:
                begin
                    if (mode[s] == MODE_RUNNING)
                        k = KIND_INVALID;
                    else
                    begin
                        expiry_us[s] = now_us + TIME_W'(period_us[s]);
                        mode[s] = MODE_RUNNING;
                    end
                end
                ACT_STOP:
                begin
                    if (mode[s] != MODE_RUNNING)
                        k = KIND_INVALID;
                    else
                        mode[s] = MODE_STOPPED;
                end
                ACT_SETP:
                begin
                    if (mode[s] != MODE_CREATED && mode[s] != MODE_RUNNING)
                        k = KIND_INVALID;
                    else
                        period_us[s] = p;
                end
                ACT_QUERY:
                begin
                end
                ACT_DESTROY:
                begin
                    if (mode[s] == MODE_RUNNING)
                        mode[s] = MODE_STOPPED;
                end
                default:
                    k = KIND_INVALID;
            endcase
            r.kind = k;
            r.slot = s;
            r.running = (mode[s] == MODE_RUNNING);
            r.last = 1'b1;
            owed.push_back(r);
        endfunction

        // Compare one accepted result beat with the oldest owed result.
        function void check_result(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                                   logic run, logic lst);
            timer_result_t e;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d slot=%0d running=%0d last=%0d",
                             k, s, run, lst);
                return;
            end
            e = owed.pop_front();
            if (k !== e.kind || s !== e.slot || run !== e.running || lst !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected kind=%0d slot=%0d running=%0d last=%0d, got kind=%0d slot=%0d running=%0d last=%0d",
                             e.kind, e.slot, e.running, e.last, k, s, run, lst);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT wiring
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [ACT_W-1:0]  action     = ACT_QUERY;
    logic [SLOT_W-1:0] slot       = '0;
    logic [MS_W-1:0]   period_ms  = '0;
    logic              oneshot    = 1'b0;
    logic [US_W-1:0]   elapsed_us = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_out;
    logic              is_running;
    logic              last;

    timer_result_board board = new();

    int unsigned cycle_count = 0;
    int          burst_left  = 1;
    bit          long_hold_req = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    oneshot_periodic_timer_bank_core #(
        .NUM_TIMERS (NUM_SLOTS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .slot       (slot),
        .period_ms  (period_ms),
        .oneshot    (oneshot),
        .elapsed_us (elapsed_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .slot_out   (slot_out),
        .is_running (is_running),
        .last       (last)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes on the pre-edge values. Note the input
    // beat first so its prediction exists before any result could be compared.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_beat(action, slot, period_ms, oneshot, elapsed_us);
            if (out_valid && out_ready)
                board.check_result(kind, slot_out, is_running, last);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, board.owed.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on segments of random style. When asked, hold off for a
    // long stretch so the output register fills and the core stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int style;
        int seg;
        int phase;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            seg   = $urandom_range(5, 60);
            repeat (seg)
            begin
                @(posedge clk);
                phase++;
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: drive one beat and hold it until accepted. Beats go out in bursts;
    // at the end of a burst drop valid for a random gap. Valid stays high
    // across back-to-back beats inside a burst.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [ACT_W-1:0] a, input logic [SLOT_W-1:0] s,
                             input logic [MS_W-1:0] pms, input logic os,
                             input logic [US_W-1:0] el);
        in_valid   <= 1'b1;
        action     <= a;
        slot       <= s;
        period_ms  <= pms;
        oneshot    <= os;
        elapsed_us <= el;
        do @(posedge clk); while (!(in_valid && in_ready));
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // Mostly short bursts, now and then a long run with no gaps.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                    : $urandom_range(1, 10);
        end
    endtask

    task automatic send_cmd(input logic [ACT_W-1:0] a, input logic [SLOT_W-1:0] s,
                            input logic [MS_W-1:0] pms, input logic os);
        send_beat(a, s, pms, os, US_W'($urandom));
    endtask

    task automatic send_tick(input logic [US_W-1:0] el);
        send_beat(ACT_TICK, SLOT_W'($urandom), MS_W'($urandom), 1'($urandom), el);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                r;
        logic [ACT_W-1:0]  a;
        logic [MS_W-1:0]   pms;
        logic [US_W-1:0]   el;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: query an idle slot; stop and set-period must be rejected cleanly.
        send_cmd(ACT_QUERY, 3'd0, 16'd0, 1'b0);
        send_cmd(ACT_STOP,  3'd0, 16'd0, 1'b0);
        send_cmd(ACT_SETP,  3'd0, 16'd5, 1'b0);
        // Start straight out of reset: runs with a zero period, periodic.
        send_cmd(ACT_START, 3'd1, 16'd0, 1'b0);
        send_cmd(ACT_START, 3'd1, 16'd0, 1'b0);
        // Zero-length tick still fires a slot whose expiry equals now.
        send_tick(16'd0);
        send_cmd(ACT_CREATE, 3'd2, 16'hFFFF, 1'b1);
        send_cmd(ACT_START,  3'd2, 16'd0, 1'b0);
        send_cmd(ACT_CREATE, 3'd7, 16'd1, 1'b0);
        send_cmd(ACT_START,  3'd7, 16'd0, 1'b0);
        send_tick(16'hFFFF);
        // Re-period running slots: expiry is kept, a zero period is accepted.
        send_cmd(ACT_SETP,   3'd7, 16'd2, 1'b0);
        send_cmd(ACT_SETP,   3'd2, 16'd0, 1'b0);
        // Create over a running slot leaves it created, not running.
        send_cmd(ACT_CREATE, 3'd1, 16'd0, 1'b0);
        send_cmd(ACT_UNUSED, 3'd3, 16'd0, 1'b0);
        send_cmd(ACT_STOP,    3'd7, 16'd0, 1'b0);
        send_cmd(ACT_DESTROY, 3'd7, 16'd0, 1'b0);
        send_cmd(ACT_DESTROY, 3'd2, 16'd0, 1'b0);
        // Nothing running: this tick must produce no result at all.
        send_tick(16'd100);
        // Start every slot and fire them all on one tick.
        for (int i = 0; i < NUM_SLOTS; i++)
            send_cmd(ACT_START, SLOT_W'(i), 16'd0, 1'b0);
        send_tick(16'hFFFF);

        // Random part: small periods and moderate ticks keep slots firing.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 3)
                long_hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 35)      a = ACT_TICK;
            else if (r < 48) a = ACT_CREATE;
            else if (r < 64) a = ACT_START;
            else if (r < 72) a = ACT_STOP;
            else if (r < 80) a = ACT_SETP;
            else if (r < 90) a = ACT_QUERY;
            else if (r < 96) a = ACT_DESTROY;
            else             a = ACT_UNUSED;

            r = $urandom_range(0, 9);
            if (r < 7)      pms = MS_W'($urandom_range(0, 5));
            else if (r < 9) pms = MS_W'($urandom_range(0, 100));
            else            pms = MS_W'($urandom);

            r = $urandom_range(0, 9);
            if (r < 6)      el = US_W'($urandom_range(0, 2500));
            else if (r < 9) el = US_W'($urandom);
            else            el = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;

            send_beat(a, SLOT_W'($urandom), pms, 1'($urandom), el);
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then allow a full scan for strays.
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (4 * (NUM_SLOTS + 3)) @(posedge clk);

        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
